// ===== hw/rtl/asmap_pkg.sv =====
// Shared constants for the affine span texture mapper: field widths,
// stream bit offsets, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package asmap_pkg;

  // Screen coordinate width; texture and row fields are one bit narrower.
  localparam int COORD_W  = 12;
  localparam int TEX_W    = COORD_W - 1;
  // A span holds up to 2^COORD_W pixels.
  localparam int SPAN_W   = COORD_W + 1;
  // Signed u step, magnitude up to 2^(COORD_W-1) + 1.
  localparam int USTEP_W  = COORD_W + 2;
  localparam int ADDR_W   = 32;
  localparam int REG_W    = 12;
  localparam int MUL_W    = COORD_W + REG_W;
  localparam int DIV_CNT_W = $clog2(COORD_W);

  // Input tdata layout, lowest field first.
  localparam int LX_LO     = 0;
  localparam int LU_LO     = LX_LO + COORD_W;
  localparam int LV_LO     = LU_LO + TEX_W;
  localparam int RX_LO     = LV_LO + TEX_W;
  localparam int RU_LO     = RX_LO + COORD_W;
  localparam int RV_LO     = RU_LO + TEX_W;
  localparam int RY_LO     = RV_LO + TEX_W;
  localparam int FIELDS_W  = RY_LO + TEX_W;
  localparam int IN_DATA_W = ((FIELDS_W + 7) / 8) * 8;

  localparam int OUT_DATA_W = 2 * ADDR_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_STRIDE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_BASE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_BASE    = CFG_IDX_W'(3);

  localparam logic [REG_W-1:0] STRIDE_RST = REG_W'(320);
  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(320);

  // Item kinds carried on in_tuser.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

endpackage

// ===== hw/rtl/affine_span_texture_mapper_top.sv =====
// Affine span texture mapper: row setup sequencer with a shared multiplier
// and a radix-2 divider, plus the per-pixel address stepper.
// Depends on asmap_pkg.
`timescale 1ns / 1ps

// Step beats: one per cycle while idle and the result register is empty or
// being taken; the result beat is registered and shows in the cycle after
// acceptance, and a new step is taken while it is being taken. A load beat
// with a positive span keeps the block busy for three passes through the
// shared multiplier and bit-per-cycle divider runs for u and v; no result beat.
// Reset (rst_n low, synchronous) idles the block, drops any span and any
// pending result, and restores the configuration registers to defaults.
module affine_span_texture_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata from bit 0: left_x, left_u, left_v, right_x, right_u, right_v,
  // row_y, zero padding.
  input  logic [asmap_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: func.
  input  logic                                in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata from bit 0: src_address, dst_address.
  output logic [asmap_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asmap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asmap_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MUL_DST = 7'b0000010,
    ST_MUL_SRC = 7'b0000100,
    ST_DIV_U   = 7'b0001000,
    ST_DIV_V   = 7'b0010000,
    ST_MUL_V   = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  localparam int CW  = asmap_pkg::COORD_W;
  localparam int TW  = asmap_pkg::TEX_W;
  localparam int SW  = asmap_pkg::SPAN_W;
  localparam int UW  = asmap_pkg::USTEP_W;
  localparam int AW  = asmap_pkg::ADDR_W;
  localparam int RW  = asmap_pkg::REG_W;
  localparam int MW  = asmap_pkg::MUL_W;
  localparam int DCW = asmap_pkg::DIV_CNT_W;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [RW-1:0] texture_stride_r;
  logic [RW-1:0] canvas_width_r;
  logic [AW-1:0] texture_base_r;
  logic [AW-1:0] canvas_base_r;

  // Latched load fields.
  logic signed [CW-1:0] lx_r;
  logic [TW-1:0]        lu_r, lv_r, ru_r, rv_r, ry_r;

  // Span and step state.
  logic          span_active_r;
  logic [SW-1:0] pixels_left_r;
  logic [SW-1:0] span_length_r;
  logic [AW-1:0] src_pointer_r, dst_pointer_r;
  logic [SW-1:0] u_acc_r, v_acc_r;
  logic [SW-1:0] u_frac_r, v_frac_r;
  logic [UW-1:0] u_whole_r, u_round_r;
  logic [AW-1:0] v_whole_r, v_round_r;

  // Shared multiplier and divider.
  logic [MW-1:0]  prod_r;
  logic [CW-1:0]  mul_a;
  logic [RW-1:0]  mul_b;
  logic [MW-1:0]  mul_p;
  logic [CW-1:0]  div_dvd_r;
  logic [SW-1:0]  div_rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic [SW:0]    div_trial;
  logic           div_ge;
  logic [SW-1:0]  div_rem_nxt;
  logic [CW-1:0]  div_dvd_nxt;
  logic           div_last;

  // Output register.
  logic          out_tvalid_r;
  logic [AW-1:0] out_src_r, out_dst_r;
  logic          out_last_r;

  // Input decode.
  logic                   in_accept, load_accept, step_accept;
  logic signed [CW-1:0]   in_lx, in_rx;
  logic signed [CW+1:0]   span_calc;
  logic                   span_pos;

  // Axis deltas and divider operands.
  logic signed [CW-1:0] du, dv;
  logic                 du_zero, du_neg, dv_zero, dv_neg;
  logic [CW-1:0]        nu, nv;
  logic [UW-1:0]        q_ext;
  logic [AW-1:0]        v_whole_val, stride_ext;

  // Step datapath.
  logic [SW:0]   u_sum, v_sum;
  logic          u_wrap, v_wrap;
  logic [SW-1:0] u_acc_nxt, v_acc_nxt;
  logic [UW-1:0] u_add;
  logic [AW-1:0] v_add, src_nxt;

  // Handshakes.
  assign in_tready   = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_accept   = in_tvalid && in_tready;
  assign load_accept = in_accept && (in_tuser == asmap_pkg::FUNC_LOAD);
  assign step_accept = in_accept && (in_tuser == asmap_pkg::FUNC_STEP) && span_active_r;
  assign cfg_ready   = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_dst_r, out_src_r};
  assign out_tlast  = out_last_r;

  // Span of the incoming row, right edge inclusive.
  assign in_lx     = in_tdata[asmap_pkg::LX_LO +: CW];
  assign in_rx     = in_tdata[asmap_pkg::RX_LO +: CW];
  assign span_calc = (CW+2)'(in_rx) - (CW+2)'(in_lx) + (CW+2)'(1);
  assign span_pos  = !span_calc[CW+1] && (span_calc != '0);

  // Deltas and Bresenham numerators |d| + 1.
  assign du      = $signed({1'b0, ru_r}) - $signed({1'b0, lu_r});
  assign dv      = $signed({1'b0, rv_r}) - $signed({1'b0, lv_r});
  assign du_zero = (du == '0);
  assign dv_zero = (dv == '0);
  assign du_neg  = du[CW-1];
  assign dv_neg  = dv[CW-1];
  assign nu      = (du_neg ? -du : du) + CW'(1);
  assign nv      = (dv_neg ? -dv : dv) + CW'(1);

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_MUL_DST: begin
        mul_a = {1'b0, ry_r};
        mul_b = canvas_width_r;
      end
      ST_MUL_SRC: begin
        mul_a = {1'b0, lv_r};
        mul_b = texture_stride_r;
      end
      default: begin
        mul_a = div_dvd_r;
        mul_b = texture_stride_r;
      end
    endcase
  end
  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // One restoring division step per cycle.
  assign div_trial   = {div_rem_r, div_dvd_r[CW-1]};
  assign div_ge      = div_trial >= {1'b0, span_length_r};
  assign div_rem_nxt = div_ge ? SW'(div_trial - {1'b0, span_length_r}) : div_trial[SW-1:0];
  assign div_dvd_nxt = {div_dvd_r[CW-2:0], div_ge};
  assign div_last    = (div_cnt_r == DCW'(CW - 1));
  assign q_ext       = {{(UW-CW){1'b0}}, div_dvd_nxt};

  // Scaled v steps from the registered product.
  assign stride_ext  = {{(AW-RW){1'b0}}, texture_stride_r};
  assign v_whole_val = dv_neg ? (AW'(0) - {{(AW-MW){1'b0}}, prod_r})
                              : {{(AW-MW){1'b0}}, prod_r};

  // Per-pixel accumulator update and source advance.
  assign u_sum     = {1'b0, u_acc_r} + {1'b0, u_frac_r};
  assign v_sum     = {1'b0, v_acc_r} + {1'b0, v_frac_r};
  assign u_wrap    = u_sum >= {1'b0, span_length_r};
  assign v_wrap    = v_sum >= {1'b0, span_length_r};
  assign u_acc_nxt = u_wrap ? SW'(u_sum - {1'b0, span_length_r}) : u_sum[SW-1:0];
  assign v_acc_nxt = v_wrap ? SW'(v_sum - {1'b0, span_length_r}) : v_sum[SW-1:0];
  assign u_add     = u_wrap ? u_round_r : u_whole_r;
  assign v_add     = v_wrap ? v_round_r : v_whole_r;
  assign src_nxt   = src_pointer_r + {{(AW-UW){u_add[UW-1]}}, u_add} + v_add;

  // Row setup sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (load_accept && span_pos) state_nxt = ST_MUL_DST;
      ST_MUL_DST: state_nxt = ST_MUL_SRC;
      ST_MUL_SRC: state_nxt = ST_DIV_U;
      ST_DIV_U:   if (div_last) state_nxt = ST_DIV_V;
      ST_DIV_V:   if (div_last) state_nxt = ST_MUL_V;
      ST_MUL_V:   state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      span_active_r <= 1'b0;
      out_tvalid_r  <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_accept) begin
        span_active_r <= 1'b0;
      end else if (state_r == ST_FINISH) begin
        span_active_r <= 1'b1;
      end else if (step_accept && (pixels_left_r == SW'(1))) begin
        span_active_r <= 1'b0;
      end
      if (step_accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if ((state_r == ST_MUL_SRC) || div_last) begin
        div_cnt_r <= '0;
      end else if ((state_r == ST_DIV_U) || (state_r == ST_DIV_V)) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      texture_stride_r <= asmap_pkg::STRIDE_RST;
      canvas_width_r   <= asmap_pkg::WIDTH_RST;
      texture_base_r   <= '0;
      canvas_base_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asmap_pkg::CFG_TEXTURE_STRIDE: texture_stride_r <= cfg_data[RW-1:0];
        asmap_pkg::CFG_CANVAS_WIDTH:   canvas_width_r   <= cfg_data[RW-1:0];
        asmap_pkg::CFG_TEXTURE_BASE:   texture_base_r   <= cfg_data[AW-1:0];
        asmap_pkg::CFG_CANVAS_BASE:    canvas_base_r    <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Load capture, setup datapath and pixel stepping.
  always_ff @(posedge clk) begin
    if (load_accept) begin
      lx_r          <= in_lx;
      lu_r          <= in_tdata[asmap_pkg::LU_LO +: TW];
      lv_r          <= in_tdata[asmap_pkg::LV_LO +: TW];
      ru_r          <= in_tdata[asmap_pkg::RU_LO +: TW];
      rv_r          <= in_tdata[asmap_pkg::RV_LO +: TW];
      ry_r          <= in_tdata[asmap_pkg::RY_LO +: TW];
      span_length_r <= span_calc[SW-1:0];
      pixels_left_r <= span_calc[SW-1:0];
    end else if (step_accept) begin
      pixels_left_r <= pixels_left_r - SW'(1);
    end

    unique case (state_r)
      ST_MUL_DST: begin
        prod_r <= mul_p;
      end
      ST_MUL_SRC: begin
        dst_pointer_r <= canvas_base_r + {{(AW-MW){1'b0}}, prod_r}
                         + {{(AW-CW){lx_r[CW-1]}}, lx_r};
        prod_r        <= mul_p;
        div_dvd_r     <= nu;
        div_rem_r     <= '0;
      end
      ST_DIV_U: begin
        if (div_cnt_r == '0) begin
          src_pointer_r <= texture_base_r + {{(AW-MW){1'b0}}, prod_r}
                           + {{(AW-TW){1'b0}}, lu_r};
        end
        if (div_last) begin
          u_frac_r  <= du_zero ? '0 : div_rem_nxt;
          u_whole_r <= du_zero ? '0 : (du_neg ? -q_ext : q_ext);
          u_round_r <= du_zero ? '0 : (du_neg ? -q_ext - UW'(1) : q_ext + UW'(1));
          div_dvd_r <= nv;
          div_rem_r <= '0;
        end else begin
          div_dvd_r <= div_dvd_nxt;
          div_rem_r <= div_rem_nxt;
        end
      end
      ST_DIV_V: begin
        if (div_last) begin
          v_frac_r <= dv_zero ? '0 : div_rem_nxt;
        end
        div_dvd_r <= div_dvd_nxt;
        div_rem_r <= div_rem_nxt;
      end
      ST_MUL_V: begin
        prod_r <= mul_p;
      end
      ST_FINISH: begin
        v_whole_r <= dv_zero ? '0 : v_whole_val;
        v_round_r <= dv_zero ? '0 : (dv_neg ? v_whole_val - stride_ext
                                            : v_whole_val + stride_ext);
        u_acc_r   <= '0;
        v_acc_r   <= '0;
      end
      default: begin
        if (step_accept) begin
          out_src_r     <= src_pointer_r;
          out_dst_r     <= dst_pointer_r;
          out_last_r    <= (pixels_left_r == SW'(1));
          dst_pointer_r <= dst_pointer_r + AW'(1);
          src_pointer_r <= src_nxt;
          u_acc_r       <= u_acc_nxt;
          v_acc_r       <= v_acc_nxt;
        end
      end
    endcase
  end

`ifndef SYNTHESIS
  // The input side only opens while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle state");

  // A new result beat comes only from an accepted step on an active span.
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r && !out_tready)) |->
      $past(in_tvalid && in_tready && in_tuser == asmap_pkg::FUNC_STEP && span_active_r))
    else $error("result beat without a step");

  // An active span always has pixels left.
  a_active_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    span_active_r |-> (pixels_left_r != '0))
    else $error("active span with no pixels left");

  // The accumulators stay below the span length.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    span_active_r |-> ((u_acc_r < span_length_r) && (v_acc_r < span_length_r)))
    else $error("accumulator out of range");

  // The last pixel closes the span.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step_accept && pixels_left_r == SW'(1)) |=> !span_active_r)
    else $error("span still active after its last pixel");
`endif

endmodule
